@@ design/bclp_pkg.sv @@
// ============================================================================
// bclp_pkg
// Shared types and constants for the button click / long-press detector.
// ============================================================================
package bclp_pkg;

    localparam int COUNT_BITS     = 8;
    localparam int TIMER_BITS     = 24;
    localparam int DEBOUNCE_BITS  = 16;
    localparam int THRESH_BITS    = 24;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 24;
    localparam int PRESS_OUT_BITS = 8;
    // common width for threshold compares, wider than the timer and threshold fields
    localparam int CMP_BITS       = 33;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DEBOUNCE_TICKS   = 4'd0,
        REG_LONG_PRESS_TICKS = 4'd1,
        REG_CLICK_GAP_TICKS  = 4'd2,
        REG_PRESSED_LEVEL    = 4'd3
    } reg_index_t;

    localparam logic EVENT_SHORT = 1'b0;
    localparam logic EVENT_LONG  = 1'b1;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [THRESH_BITS-1:0]   LONG_PRESS_RESET = 24'd1500;
    localparam logic [THRESH_BITS-1:0]   CLICK_GAP_RESET  = 24'd500;
    localparam logic                     PRESSED_RESET    = 1'b0;

    typedef struct packed {
        logic [DEBOUNCE_BITS-1:0] debounce_ticks;
        logic [THRESH_BITS-1:0]   long_press_ticks;
        logic [THRESH_BITS-1:0]   click_gap_ticks;
        logic                     pressed_level;
    } cfg_t;

    typedef struct packed {
        logic                      event_kind;
        logic [PRESS_OUT_BITS-1:0] press_count;
    } result_t;

endpackage

@@ design/bclp_cfg_regs.sv @@
// ============================================================================
// bclp_cfg_regs
// Configuration register file; unknown indexes are ignored.
// ============================================================================
module bclp_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bclp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bclp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output bclp_pkg::cfg_t                       cfg
);

    bclp_pkg::cfg_t cfg_reg;
    bclp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bclp_pkg::REG_DEBOUNCE_TICKS:
                    cfg_next.debounce_ticks = cfg_data[bclp_pkg::DEBOUNCE_BITS-1:0];
                bclp_pkg::REG_LONG_PRESS_TICKS:
                    cfg_next.long_press_ticks = cfg_data[bclp_pkg::THRESH_BITS-1:0];
                bclp_pkg::REG_CLICK_GAP_TICKS:
                    cfg_next.click_gap_ticks = cfg_data[bclp_pkg::THRESH_BITS-1:0];
                bclp_pkg::REG_PRESSED_LEVEL:
                    cfg_next.pressed_level = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= bclp_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_ticks <= bclp_pkg::LONG_PRESS_RESET;
            cfg_reg.click_gap_ticks  <= bclp_pkg::CLICK_GAP_RESET;
            cfg_reg.pressed_level    <= bclp_pkg::PRESSED_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/bclp_core.sv @@
// ============================================================================
// bclp_core
// Debounce, press counting and event decision, one tick per accepted request.
// ============================================================================
module bclp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              tick,
    input  logic              level,
    input  bclp_pkg::cfg_t    cfg,
    output logic              res_valid,
    output bclp_pkg::result_t res
);

    localparam logic [bclp_pkg::TIMER_BITS-1:0]    TIMER_MAX = '1;
    localparam logic [bclp_pkg::COUNT_BITS-1:0]    COUNT_MAX = '1;
    localparam logic [bclp_pkg::DEBOUNCE_BITS-1:0] DEB_MAX   = '1;
    localparam logic [bclp_pkg::CMP_BITS-1:0]      PRESS_SAT = bclp_pkg::CMP_BITS'(255);

    logic                               stable_reg,   stable_next;
    logic [bclp_pkg::DEBOUNCE_BITS-1:0] deb_reg,      deb_next;
    logic [bclp_pkg::TIMER_BITS-1:0]    elapsed_reg,  elapsed_next;
    logic [bclp_pkg::COUNT_BITS-1:0]    pending_reg,  pending_next;

    logic [bclp_pkg::TIMER_BITS-1:0]    elapsed_inc;
    logic [bclp_pkg::DEBOUNCE_BITS-1:0] deb_inc;
    logic [bclp_pkg::CMP_BITS-1:0]      elapsed_w;

    assign elapsed_inc = (elapsed_reg == TIMER_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign deb_inc     = (deb_reg == DEB_MAX) ? deb_reg : deb_reg + 1'b1;
    assign elapsed_w   = bclp_pkg::CMP_BITS'(elapsed_inc);

    always_comb begin
        stable_next     = stable_reg;
        deb_next        = deb_reg;
        elapsed_next    = elapsed_reg;
        pending_next    = pending_reg;
        res_valid       = 1'b0;
        res.event_kind  = bclp_pkg::EVENT_SHORT;
        res.press_count = (bclp_pkg::CMP_BITS'(pending_reg) > PRESS_SAT) ? 8'hFF :
                          bclp_pkg::PRESS_OUT_BITS'(pending_reg);
        if (tick) begin
            elapsed_next = elapsed_inc;
            if (level != stable_reg) begin
                deb_next = deb_inc;
                if (deb_inc >= cfg.debounce_ticks) begin
                    // edge accepted
                    stable_next  = level;
                    elapsed_next = '0;
                    deb_next     = '0;
                    if (level == cfg.pressed_level && pending_reg != COUNT_MAX)
                        pending_next = pending_reg + 1'b1;
                end
            end else begin
                deb_next = '0;
                if (pending_reg != '0) begin
                    if (stable_reg == cfg.pressed_level) begin
                        if (elapsed_w >= bclp_pkg::CMP_BITS'(cfg.long_press_ticks)) begin
                            res_valid       = 1'b1;
                            res.event_kind  = bclp_pkg::EVENT_LONG;
                            res.press_count = bclp_pkg::PRESS_OUT_BITS'(1);
                            pending_next    = '0;
                        end
                    end else if (elapsed_w >= bclp_pkg::CMP_BITS'(cfg.click_gap_ticks)) begin
                        res_valid    = 1'b1;
                        pending_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg  <= ~bclp_pkg::PRESSED_RESET;
            deb_reg     <= '0;
            elapsed_reg <= '0;
            pending_reg <= '0;
        end else begin
            stable_reg  <= stable_next;
            deb_reg     <= deb_next;
            elapsed_reg <= elapsed_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ design/bclp_out_buf.sv @@
// ============================================================================
// bclp_out_buf
// Result register with a skid stage; ready drops only when both are full.
// ============================================================================
module bclp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bclp_pkg::result_t push_data,
    output logic              can_push,
    output logic              m_valid,
    input  logic              m_ready,
    output bclp_pkg::result_t m_data
);

    logic              out_valid_reg,  out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bclp_pkg::result_t out_reg,        out_next;
    bclp_pkg::result_t skid_reg,       skid_next;
    logic              take;

    assign take     = out_valid_reg & m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign can_push = ~skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end else begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end else if (!out_valid_reg) begin
            out_valid_next = push;
            out_next       = push_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

@@ design/button_click_long_press_detect_top.sv @@
// ============================================================================
// button_click_long_press_detect_top
// Debounced button with multi-click and long-press event detection.
// ============================================================================
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | s_valid / s_ready     | s_button_level (one tick per request)
//  result   | m_valid / m_ready     | m_event_kind, m_press_count
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One request per cycle while s_ready is high: the core updates its counters
//  in a single pass and its result is registered in the output register or skid.
//  s_ready stays high unless both the output register and the skid stage
//  hold results, i.e. the result side has stalled for more than one result.
//  Synchronous active-low reset restores register defaults, sets the stable
//  level to released and clears all counters and buffered results.
//  cfg_ready is always high; writes take effect on the next cycle.
//
module button_click_long_press_detect_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input ticks
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_button_level,
    // result events
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_event_kind,
    output logic [bclp_pkg::PRESS_OUT_BITS-1:0] m_press_count,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bclp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bclp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    bclp_pkg::cfg_t    cfg;
    bclp_pkg::result_t core_res;
    bclp_pkg::result_t out_res;
    logic              core_res_valid;
    logic              tick;

    // a request is one tick of the detector
    assign tick = s_valid & s_ready;

    bclp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bclp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (tick),
        .level     (s_button_level),
        .cfg       (cfg),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    // result register plus skid keeps ticks flowing through a one-deep stall
    bclp_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_res_valid),
        .push_data (core_res),
        .can_push  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_res)
    );

    assign m_event_kind  = out_res.event_kind;
    assign m_press_count = out_res.press_count;

endmodule

@@ bench/button_click_long_press_detect_top_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// button_click_long_press_detect_top_tb
// Drives sampled button ticks through the debounce / click / long-press
// detector under random stalls on both channels. An in-bench model of the
// detector predicts every event, and each event the block emits is checked
// against it. Glitch runs under the reset defaults come first, then a short
// table of hand-traced ticks with fixed expected events. Random click, hold
// and bounce sequences follow, over several register settings that include zero and full-scale values.
// ============================================================================
module button_click_long_press_detect_top_tb;

    localparam int SETTLE_CYCLES   = 16;   // idle wait after drains and register writes
    localparam int HOLD_CYCLES     = 60;   // long result-side hold-off
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DIRECTED_ROWS   = 22;
    localparam logic [bclp_pkg::CFG_INDEX_BITS-1:0] UNUSED_REG_INDEX = 4'd9;

    // active-low button used in the directed table
    localparam logic LVL_DOWN = 1'b0;
    localparam logic LVL_UP   = 1'b1;

    typedef enum logic {CHECK_MODEL, CHECK_TYPED} row_check_t;

    typedef struct packed {
        logic              level;
        row_check_t        check;
        bclp_pkg::result_t ev;
    } tick_row_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic                                s_button_level;
    logic                                m_valid;
    logic                                m_ready;
    logic                                m_event_kind;
    logic [bclp_pkg::PRESS_OUT_BITS-1:0] m_press_count;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [bclp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bclp_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    button_click_long_press_detect_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_press_count  (m_press_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Per-request check mode; driven with the tick so the monitor samples
    // the value that belongs to the request being accepted.
    row_check_t        tick_check;
    bclp_pkg::result_t tick_typed;

    bit idle_on      = 1'b1;   // random bubbles on both channels
    bit hold_results = 1'b0;   // one long m_ready hold-off

    int error_count     = 0;
    int ticks_sent      = 0;
    int events_checked  = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;

    tick_row_t directed_ticks [DIRECTED_ROWS];

    // Detector model: its own copy of the registers and counters.
    bclp_pkg::cfg_t                     live_cfg;
    logic                               settled_level;
    logic [bclp_pkg::DEBOUNCE_BITS-1:0] bounce_run;
    logic [bclp_pkg::TIMER_BITS-1:0]    since_edge;
    logic [bclp_pkg::COUNT_BITS-1:0]    presses_held;
    bclp_pkg::result_t                  pending_events [$];

    // One tick of the detector. Returns whether an event fires on this tick.
    function automatic void advance_detector(input logic lvl, output bit fired,
                                             output bclp_pkg::result_t ev);
        fired = 1'b0;
        ev    = '0;
        if (since_edge != '1)
            since_edge = since_edge + 1'b1;
        if (lvl != settled_level) begin
            if (bounce_run != '1)
                bounce_run = bounce_run + 1'b1;
            // a zero debounce setting accepts on the first differing tick
            if (bounce_run >= live_cfg.debounce_ticks) begin
                settled_level = lvl;
                if (lvl == live_cfg.pressed_level && presses_held != '1)
                    presses_held = presses_held + 1'b1;
                since_edge = '0;
                bounce_run = '0;
            end
        end else begin
            bounce_run = '0;
            if (presses_held != '0) begin
                if (settled_level == live_cfg.pressed_level) begin
                    if (since_edge >= live_cfg.long_press_ticks) begin
                        fired          = 1'b1;
                        ev.event_kind  = bclp_pkg::EVENT_LONG;
                        ev.press_count = bclp_pkg::PRESS_OUT_BITS'(1);
                        presses_held   = '0;
                    end
                end else if (since_edge >= live_cfg.click_gap_ticks) begin
                    fired         = 1'b1;
                    ev.event_kind = bclp_pkg::EVENT_SHORT;
                    if (presses_held > {bclp_pkg::PRESS_OUT_BITS{1'b1}})
                        ev.press_count = '1;
                    else
                        ev.press_count = presses_held;
                    presses_held = '0;
                end
            end
        end
    endfunction

    function automatic tick_row_t mk_row(input logic lvl, input row_check_t chk,
                                         input logic kind, input int count);
        tick_row_t r;
        r.level          = lvl;
        r.check          = chk;
        r.ev.event_kind  = kind;
        r.ev.press_count = bclp_pkg::PRESS_OUT_BITS'(count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: register writes and ticks feed the model, events are checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        bit                fired;
        bclp_pkg::result_t ev;
        bclp_pkg::result_t want;
        if (!aresetn) begin
            live_cfg.debounce_ticks   = bclp_pkg::DEBOUNCE_RESET;
            live_cfg.long_press_ticks = bclp_pkg::LONG_PRESS_RESET;
            live_cfg.click_gap_ticks  = bclp_pkg::CLICK_GAP_RESET;
            live_cfg.pressed_level    = bclp_pkg::PRESSED_RESET;
            settled_level             = ~bclp_pkg::PRESSED_RESET;
            bounce_run                = '0;
            since_edge                = '0;
            presses_held              = '0;
            pending_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    bclp_pkg::REG_DEBOUNCE_TICKS:
                        live_cfg.debounce_ticks = cfg_data[bclp_pkg::DEBOUNCE_BITS-1:0];
                    bclp_pkg::REG_LONG_PRESS_TICKS:
                        live_cfg.long_press_ticks = cfg_data[bclp_pkg::THRESH_BITS-1:0];
                    bclp_pkg::REG_CLICK_GAP_TICKS:
                        live_cfg.click_gap_ticks = cfg_data[bclp_pkg::THRESH_BITS-1:0];
                    bclp_pkg::REG_PRESSED_LEVEL:
                        live_cfg.pressed_level = cfg_data[0];
                    default: ;  // unmapped index: no effect
                endcase
            end
            // results are checked before this edge's tick is modeled; a tick
            // can never produce its event on the edge it is accepted
            if (m_valid && m_ready) begin
                events_checked++;
                if (pending_events.size() == 0) begin
                    error_count++;
                    $error("unexpected event: event_kind %0d press_count %0d",
                           m_event_kind, m_press_count);
                end else begin
                    want = pending_events.pop_front();
                    if (m_event_kind !== want.event_kind) begin
                        error_count++;
                        $error("event_kind: expected %0d, actual %0d",
                               want.event_kind, m_event_kind);
                    end
                    if (m_press_count !== want.press_count) begin
                        error_count++;
                        $error("press_count: expected %0d, actual %0d",
                               want.press_count, m_press_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_detector(s_button_level, fired, ev);
                if (tick_check == CHECK_TYPED)
                    pending_events.push_back(tick_typed);
                else if (fired)
                    pending_events.push_back(ev);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted request on any channel resets it
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles, %0d events outstanding",
                     quiet_cycles, pending_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready stretches, short stalls, and one long hold-off that
    // lets the output buffer fill so s_ready drops
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Offer one tick and wait for acceptance; may leave a bubble after it.
    task automatic send_tick(input logic lvl, input row_check_t chk,
                             input bclp_pkg::result_t typed);
        s_valid        <= 1'b1;
        s_button_level <= lvl;
        tick_check     <= chk;
        tick_typed     <= typed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_level(input logic lvl);
        send_tick(lvl, CHECK_MODEL, '0);
    endtask

    // A few bounce ticks, then the level held for len ticks.
    task automatic hold_level(input logic lvl, input int len);
        int nb;
        nb = $urandom_range(0, 2);
        repeat (nb) send_level(1'($urandom_range(0, 1)));
        repeat (len) send_level(lvl);
    endtask

    // Sender stops until every predicted event has come out, then lets the
    // pipeline settle (ticks that fire nothing may still be in flight).
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bclp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [bclp_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_writes++;
    endtask

    // Writes every register while the block is idle. Unused data bits are
    // randomized to check the field masking.
    task automatic set_config(input logic [bclp_pkg::DEBOUNCE_BITS-1:0] deb,
                              input logic [bclp_pkg::THRESH_BITS-1:0] lng,
                              input logic [bclp_pkg::THRESH_BITS-1:0] gap,
                              input logic pol, input bit stray);
        logic [31:0] r;
        drain_results();
        r = $urandom;
        write_reg(bclp_pkg::REG_DEBOUNCE_TICKS, {r[7:0], deb});
        write_reg(bclp_pkg::REG_LONG_PRESS_TICKS, lng);
        write_reg(bclp_pkg::REG_CLICK_GAP_TICKS, gap);
        r = $urandom;
        write_reg(bclp_pkg::REG_PRESSED_LEVEL, {r[22:0], pol});
        if (stray) begin
            r = $urandom;
            write_reg(UNUSED_REG_INDEX, r[bclp_pkg::CFG_DATA_BITS-1:0]);
        end
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed click runs and long holds sized to the current
    // thresholds (capped so large settings stay cheap), plus raw noise.
    task automatic random_clicks(input int n);
        int   stop_at;
        int   d;
        int   lng;
        int   gp;
        int   hold;
        logic pl;
        stop_at = ticks_sent + n;
        d   = (live_cfg.debounce_ticks == 0) ? 1 : int'(live_cfg.debounce_ticks);
        lng = (live_cfg.long_press_ticks > 60) ? 60 : int'(live_cfg.long_press_ticks);
        gp  = (live_cfg.click_gap_ticks > 60) ? 60 : int'(live_cfg.click_gap_ticks);
        pl  = live_cfg.pressed_level;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0)
                        hold = d + lng + $urandom_range(0, 3);
                    else
                        hold = $urandom_range(d, d + lng / 2);
                    hold_level(pl, hold);
                    hold_level(!pl, $urandom_range(d, d + gp / 2));
                end
                hold_level(!pl, gp + $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table: traced by hand from reset state with debounce 2,
    // long press 3, click gap 2, active-low button. Two rows carry a fixed
    // expected event; the rest are checked against the model.
    // ------------------------------------------------------------------------
    initial begin
        directed_ticks[0]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[1]  = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0); // aborted
        directed_ticks[2]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[3]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0); // press
        directed_ticks[4]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[5]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[6]  = mk_row(LVL_DOWN, CHECK_TYPED, bclp_pkg::EVENT_LONG,  1); // held 3
        directed_ticks[7]  = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[8]  = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[9]  = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0); // release
        directed_ticks[10] = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[11] = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0); // click 1
        directed_ticks[12] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[13] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[14] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        // gap reached, but the level is unstable
        directed_ticks[15] = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[16] = mk_row(LVL_DOWN, CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0); // click 2
        directed_ticks[17] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[18] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[19] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
        directed_ticks[20] = mk_row(LVL_UP,   CHECK_TYPED, bclp_pkg::EVENT_SHORT, 2); // double
        directed_ticks[21] = mk_row(LVL_UP,   CHECK_MODEL, bclp_pkg::EVENT_SHORT, 0);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_button_level <= 1'b1;
        tick_check     <= CHECK_MODEL;
        tick_typed     <= '0;
        cfg_valid      <= 1'b0;
        cfg_index      <= bclp_pkg::REG_DEBOUNCE_TICKS;
        cfg_data       <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: short pressed glitches stay under the default
        // debounce, so the released level must survive untouched.
        repeat (4) begin
            repeat ($urandom_range(1, 30)) send_level(1'b0);
            repeat ($urandom_range(1, 10)) send_level(1'b1);
        end

        set_config(16'd2, 24'd3, 24'd2, 1'b0, 1'b0);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_tick(directed_ticks[i].level, directed_ticks[i].check, directed_ticks[i].ev);

        // Zero debounce and zero thresholds: events on the first stable tick.
        // The long hold-off lands here, where events are dense.
        set_config(16'd0, 24'd0, 24'd0, 1'b0, 1'b0);
        hold_results = 1'b1;
        random_clicks(120);

        // Active-high button with mid-size thresholds; the sender pauses
        // half way until every event has come out.
        set_config(16'($urandom_range(1, 4)), 24'($urandom_range(8, 40)),
                   24'($urandom_range(4, 20)), 1'b1, 1'b0);
        random_clicks(100);
        drain_results();
        random_clicks(100);

        // Press count saturation: more than 255 clicks with no stable tick
        // in between, then a released gap ends the run.
        set_config(16'd1, 24'd2000, 24'd10, 1'b0, 1'b0);
        repeat (14) send_level(1'b1);
        repeat (260) begin
            send_level(1'b0);
            send_level(1'b1);
        end
        repeat (14) send_level(1'b1);

        // Full-scale registers plus a write to an unmapped index: nothing
        // can settle or fire here.
        set_config(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
        repeat (80) send_level(1'($urandom_range(0, 1)));

        // Last stretch with both sides always ready.
        set_config(16'($urandom_range(1, 3)), 24'($urandom_range(4, 20)),
                   24'($urandom_range(3, 12)), 1'($urandom_range(0, 1)), 1'b0);
        idle_on = 1'b0;
        random_clicks(150);

        drain_results();
        $display("Sent %0d ticks, checked %0d events, %0d register writes.",
                 ticks_sent, events_checked, reg_writes);
        $display("Covered aborts, click runs, long holds, edge settings and back-pressure.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
